// ===== src/crse_pkg.sv =====
// Package for the connection rule stack evaluator.
// Holds sizes, opcodes, sequencer states and the structs used by the stack, test unit and top level.
// No dependencies.
`default_nettype none

package crse_pkg;

  // Store and stack sizes
  localparam int unsigned PROGRAM_DEPTH = 256;
  localparam int unsigned STACK_DEPTH   = 32;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned PORT_W      = 16;
  localparam int unsigned CFG_LEN_W   = 9;
  localparam int unsigned PROG_AW     = $clog2(PROGRAM_DEPTH);
  localparam int unsigned LEN_W       = $clog2(PROGRAM_DEPTH + 1);
  localparam int unsigned STK_IDX_W   = $clog2(STACK_DEPTH);
  localparam int unsigned STK_DEPTH_W = $clog2(STACK_DEPTH + 1);

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam logic [APB_AW-3:0] REG_PROGRAM_LENGTH = '0;

  // Item operations
  localparam logic OPER_WRITE = 1'b0;
  localparam logic OPER_EVAL  = 1'b1;

  // Rule opcodes, compared over the full word
  localparam logic [WORD_W-1:0] OP_USER  = 32'd1;
  localparam logic [WORD_W-1:0] OP_LPORT = 32'd2;
  localparam logic [WORD_W-1:0] OP_RPORT = 32'd3;
  localparam logic [WORD_W-1:0] OP_LADDR = 32'd4;
  localparam logic [WORD_W-1:0] OP_RADDR = 32'd5;
  localparam logic [WORD_W-1:0] OP_EXE   = 32'd6;
  localparam logic [WORD_W-1:0] OP_OR    = 32'd64;
  localparam logic [WORD_W-1:0] OP_AND   = 32'd65;
  localparam logic [WORD_W-1:0] OP_NOT   = 32'd66;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPCODE,
    ST_OPER0,
    ST_OPER1,
    ST_RESP
  } state_e;

  // Stack commands
  typedef enum logic [2:0] {
    STK_NONE,
    STK_CLEAR,
    STK_PUSH,
    STK_OR,
    STK_AND,
    STK_NOT
  } stk_op_e;

  typedef struct packed {
    stk_op_e op;
    logic    bit_val;
  } stk_cmd_t;

  typedef struct packed {
    logic [STK_DEPTH_W-1:0] depth;
    logic                   tos;
    logic                   empty;
    logic                   full;
    logic                   has_two;
  } stk_stat_t;

  // Connection tuple under test
  typedef struct packed {
    logic [WORD_W-1:0] user_id;
    logic [WORD_W-1:0] local_address;
    logic [PORT_W-1:0] local_port;
    logic [WORD_W-1:0] remote_address;
    logic [PORT_W-1:0] remote_port;
  } tuple_t;

endpackage

`default_nettype wire

// ===== src/crse_prog_mem.sv =====
// Rule program store: one write port, one read port with registered data.
// Depends on crse_pkg.
`default_nettype none

module crse_prog_mem (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [crse_pkg::PROG_AW-1:0] waddr_i,
  input  wire logic [crse_pkg::WORD_W-1:0]  wdata_i,
  input  wire logic [crse_pkg::PROG_AW-1:0] raddr_i,
  output logic      [crse_pkg::WORD_W-1:0]  rdata_o
);
  import crse_pkg::*;

  logic [WORD_W-1:0] mem [PROGRAM_DEPTH];
  logic [WORD_W-1:0] rdata_q;

  // Write a word, read the addressed word into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/crse_test_unit.sv =====
// Shared test unit: evaluates one tuple test from its opcode and operand words.
// Depends on crse_pkg.
`default_nettype none

module crse_test_unit (
  input  wire logic [crse_pkg::WORD_W-1:0] opcode_i,
  input  wire logic [crse_pkg::WORD_W-1:0] opnd_a_i,
  input  wire logic [crse_pkg::WORD_W-1:0] opnd_b_i,
  input  wire crse_pkg::tuple_t            tuple_i,
  output logic                             result_o
);
  import crse_pkg::*;

  // Compare the tuple field that the opcode selects
  always_comb begin
    case (opcode_i)
      OP_USER:  result_o = (tuple_i.user_id == opnd_a_i);
      OP_LPORT: result_o = (tuple_i.local_port >= opnd_a_i[PORT_W-1:0]) &&
                           (tuple_i.local_port <= opnd_b_i[PORT_W-1:0]);
      OP_RPORT: result_o = (tuple_i.remote_port >= opnd_a_i[PORT_W-1:0]) &&
                           (tuple_i.remote_port <= opnd_b_i[PORT_W-1:0]);
      OP_LADDR: result_o = ((tuple_i.local_address & opnd_b_i) == opnd_a_i);
      OP_RADDR: result_o = ((tuple_i.remote_address & opnd_b_i) == opnd_a_i);
      // Names are unavailable, so the glob test always passes
      OP_EXE:   result_o = 1'b1;
      default:  result_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/crse_truth_stack.sv =====
// One-bit truth stack with the top entry cached in a register.
// Depends on crse_pkg. The sequencer guarantees no underflow or overflow.
`default_nettype none

module crse_truth_stack (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire crse_pkg::stk_cmd_t   cmd_i,
  output crse_pkg::stk_stat_t       stat_o
);
  import crse_pkg::*;

  logic [STK_DEPTH_W-1:0] depth_q, depth_d;
  logic                   tos_q, tos_d;
  logic                   below_q [STACK_DEPTH];
  logic [STK_DEPTH_W-1:0] depth_m1;
  logic [STK_DEPTH_W-1:0] depth_m2;
  logic                   second;
  logic                   spill;

  assign depth_m1 = depth_q - STK_DEPTH_W'(1);
  assign depth_m2 = depth_q - STK_DEPTH_W'(2);
  assign second   = below_q[depth_m2[STK_IDX_W-1:0]];

  // Work out the new top and depth
  always_comb begin
    depth_d = depth_q;
    tos_d   = tos_q;
    spill   = 1'b0;
    case (cmd_i.op)
      STK_CLEAR: depth_d = '0;
      STK_PUSH: begin
        spill   = (depth_q != '0);
        tos_d   = cmd_i.bit_val;
        depth_d = depth_q + STK_DEPTH_W'(1);
      end
      STK_OR: begin
        tos_d   = tos_q | second;
        depth_d = depth_m1;
      end
      STK_AND: begin
        tos_d   = tos_q & second;
        depth_d = depth_m1;
      end
      STK_NOT:  tos_d = ~tos_q;
      default:  ;
    endcase
  end

  // Hold the depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  // Spill the old top below the new one on a push
  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    if (spill) begin
      below_q[depth_m1[STK_IDX_W-1:0]] <= tos_q;
    end
  end

  assign stat_o.depth   = depth_q;
  assign stat_o.tos     = tos_q;
  assign stat_o.empty   = (depth_q == '0);
  assign stat_o.full    = (depth_q == STK_DEPTH_W'(STACK_DEPTH));
  assign stat_o.has_two = (depth_q >= STK_DEPTH_W'(2));

endmodule

`default_nettype wire

// ===== src/connection_rule_stack_evaluator.sv =====
// Connection rule stack evaluator, top level with the program sequencer.
// Depends on crse_pkg, crse_prog_mem, crse_test_unit and crse_truth_stack.
//
// Usage: the input channel carries one transaction per item. operation 0
// writes program_word into the rule store at word_index; operation 1 runs
// the stored postfix program, program_length words long (set through the
// APB port, saturated to the store depth), against the connection tuple.
// Every item answers with one output transaction: matched and status.
// Writes answer matched 0, status 0; a malformed program answers status 1.
//
// Timing: an item is taken in the cycle in_ready_o is high; the result is
// offered on the next cycle after the work ends. A write goes straight
// from acceptance to its result. An evaluation reads each program word in
// turn and then makes the final depth check; a fault stops it early. The
// walk is set by the single read port of the program store, one word per
// cycle. in_ready_o is low from acceptance through the result transaction
// and rises in the next cycle; a stalled receiver holds the result and the
// block. Reset clears the length register to 0, empties the stack and
// idles the sequencer; the store holds no reset value.
`default_nettype none

module connection_rule_stack_evaluator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              operation_i,
  input  wire logic [7:0]                        word_index_i,
  input  wire logic [crse_pkg::WORD_W-1:0]       program_word_i,
  input  wire logic [crse_pkg::WORD_W-1:0]       user_id_i,
  input  wire logic [crse_pkg::WORD_W-1:0]       local_address_i,
  input  wire logic [crse_pkg::PORT_W-1:0]       local_port_i,
  input  wire logic [crse_pkg::WORD_W-1:0]       remote_address_i,
  input  wire logic [crse_pkg::PORT_W-1:0]       remote_port_i,
  // Output channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   matched_o,
  output logic                                   status_o,
  // Configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [crse_pkg::APB_AW-1:0]       paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import crse_pkg::*;

  state_e                 state_q, state_d;
  logic [LEN_W-1:0]       ip_q, ip_d;
  logic [WORD_W-1:0]      op_q, op_d;
  logic [WORD_W-1:0]      w0_q, w0_d;
  logic                   matched_q, matched_d;
  logic                   status_q, status_d;
  tuple_t                 tuple_q;
  logic [CFG_LEN_W-1:0]   prog_len_q;
  logic [LEN_W-1:0]       len;

  logic                   in_fire;
  logic                   out_fire;
  logic                   cfg_wr;
  logic                   mem_we;
  logic [WORD_W-1:0]      rd_word;
  logic [WORD_W-1:0]      opnd_a;
  logic                   test_bit;
  stk_cmd_t               stk_cmd;
  stk_stat_t              stk_stat;

  // Opcode decode
  logic [1:0]             need;
  logic                   is_bin;
  logic                   is_not;
  logic                   bad_op;
  logic                   at_end;
  logic                   trunc;
  logic                   op_fault;
  logic                   two_opnd;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  // Configuration register
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[APB_AW-1:2] == REG_PROGRAM_LENGTH);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q <= '0;
    end else if (cfg_wr) begin
      prog_len_q <= pwdata[CFG_LEN_W-1:0];
    end
  end

  assign prdata = (paddr[APB_AW-1:2] == REG_PROGRAM_LENGTH) ? 32'(prog_len_q) : '0;

  // Saturate the length to the store depth
  assign len = (32'(prog_len_q) > PROGRAM_DEPTH) ? LEN_W'(PROGRAM_DEPTH)
                                                  : LEN_W'(prog_len_q);

  // Program store
  assign mem_we = in_fire && (operation_i == OPER_WRITE)
                  && (32'(word_index_i) < PROGRAM_DEPTH);

  crse_prog_mem u_prog_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (PROG_AW'(word_index_i)),
    .wdata_i (program_word_i),
    .raddr_i (ip_d[PROG_AW-1:0]),
    .rdata_o (rd_word)
  );

  // Shared test unit: first operand is held when a second one follows
  assign opnd_a = (state_q == ST_OPER1) ? w0_q : rd_word;

  crse_test_unit u_test_unit (
    .opcode_i (op_q),
    .opnd_a_i (opnd_a),
    .opnd_b_i (rd_word),
    .tuple_i  (tuple_q),
    .result_o (test_bit)
  );

  crse_truth_stack u_truth_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (stk_cmd),
    .stat_o (stk_stat)
  );

  // Decode the word at the instruction pointer
  always_comb begin
    need   = 2'd0;
    is_bin = 1'b0;
    is_not = 1'b0;
    bad_op = 1'b0;
    case (rd_word)
      OP_USER, OP_EXE:                      need = 2'd1;
      OP_LPORT, OP_RPORT, OP_LADDR, OP_RADDR: need = 2'd2;
      OP_OR, OP_AND:                        is_bin = 1'b1;
      OP_NOT:                               is_not = 1'b1;
      default:                              bad_op = 1'b1;
    endcase
    at_end   = (ip_q >= len);
    trunc    = ({1'b0, ip_q} + (LEN_W + 1)'(need) + (LEN_W + 1)'(1)) > {1'b0, len};
    op_fault = bad_op || trunc || (is_bin && !stk_stat.has_two)
               || (is_not && stk_stat.empty);
    two_opnd = (op_q != OP_USER) && (op_q != OP_EXE);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (operation_i == OPER_EVAL) ? ST_OPCODE : ST_RESP;
        end
      end
      ST_OPCODE: begin
        if (at_end || op_fault) begin
          state_d = ST_RESP;
        end else if (need != 2'd0) begin
          state_d = ST_OPER0;
        end
      end
      ST_OPER0: begin
        if (two_opnd) begin
          state_d = ST_OPER1;
        end else begin
          state_d = stk_stat.full ? ST_RESP : ST_OPCODE;
        end
      end
      ST_OPER1: state_d = stk_stat.full ? ST_RESP : ST_OPCODE;
      ST_RESP: begin
        if (out_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and stack control
  always_comb begin
    ip_d        = ip_q;
    op_d        = op_q;
    w0_d        = w0_q;
    matched_d   = matched_q;
    status_d    = status_q;
    stk_cmd.op      = STK_NONE;
    stk_cmd.bit_val = test_bit;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ip_d      = '0;
          matched_d = 1'b0;
          status_d  = 1'b0;
          if (operation_i == OPER_EVAL) begin
            stk_cmd.op = STK_CLEAR;
          end
        end
      end
      ST_OPCODE: begin
        op_d = rd_word;
        if (at_end) begin
          matched_d = (stk_stat.depth == STK_DEPTH_W'(1)) && stk_stat.tos;
          status_d  = (stk_stat.depth != STK_DEPTH_W'(1));
        end else if (op_fault) begin
          matched_d = 1'b0;
          status_d  = 1'b1;
        end else begin
          ip_d = ip_q + LEN_W'(1);
          case (rd_word)
            OP_OR:   stk_cmd.op = STK_OR;
            OP_AND:  stk_cmd.op = STK_AND;
            OP_NOT:  stk_cmd.op = STK_NOT;
            default: stk_cmd.op = STK_NONE;
          endcase
        end
      end
      ST_OPER0: begin
        w0_d = rd_word;
        ip_d = ip_q + LEN_W'(1);
        if (!two_opnd) begin
          if (stk_stat.full) begin
            matched_d = 1'b0;
            status_d  = 1'b1;
          end else begin
            stk_cmd.op = STK_PUSH;
          end
        end
      end
      ST_OPER1: begin
        ip_d = ip_q + LEN_W'(1);
        if (stk_stat.full) begin
          matched_d = 1'b0;
          status_d  = 1'b1;
        end else begin
          stk_cmd.op = STK_PUSH;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ip_q      <= ip_d;
    op_q      <= op_d;
    w0_q      <= w0_d;
    matched_q <= matched_d;
    status_q  <= status_d;
    if (in_fire) begin
      tuple_q.user_id        <= user_id_i;
      tuple_q.local_address  <= local_address_i;
      tuple_q.local_port     <= local_port_i;
      tuple_q.remote_address <= remote_address_i;
      tuple_q.remote_port    <= remote_port_i;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_RESP);
  assign matched_o   = matched_q;
  assign status_o    = status_q;

  // Checks
  a_ready_excl_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  a_fault_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> !matched_o)
    else $error("malformed result reports a match");

  a_write_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (operation_i == OPER_WRITE) |=> out_valid_o && !status_o && !matched_o)
    else $error("write transaction not answered with a clean result");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_stat.depth <= STK_DEPTH_W'(STACK_DEPTH))
    else $error("truth stack depth beyond its size");

endmodule

`default_nettype wire
